[hw/rtl/cms_pkg.sv]
`timescale 1ns / 1ps
package cms_pkg;

    // Default sizes of the list, the segment table and the mailbox bank
    localparam int ENTRIES_DEF   = 64;
    localparam int SEGMENTS_DEF  = 8;
    localparam int MAILBOXES_DEF = 32;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int ID_W    = 11;
    localparam int LEN_W   = 4;
    localparam int CYC_W   = 16;
    localparam int MBOX_W  = 5;
    localparam int ENTRY_W = 6;
    localparam int DUP_W   = 4;
    localparam int RATIO_W = 7;
    localparam int CFG_W   = 7;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_ACCEPT = 2'd3;

    // Register indexes
    localparam logic CFG_DUP_LIMIT = 1'b0;
    localparam logic CFG_RATIO     = 1'b1;

    localparam logic [DUP_W-1:0] DUP_MAX = 4'd15;

endpackage

[hw/rtl/cms_ram.sv]
`timescale 1ns / 1ps
module cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/can_mailbox_id_scheduler_core.sv]
`timescale 1ns / 1ps
// Receive mailbox ID scheduler. Load transactions (tuser = 0) append a list
// entry (ID, length) in arrival order; past the first entry, a rise above the
// highest cycle time so far opens a new segment (while the table has room)
// whose mailbox range is sized by ceil(position / filter_ratio), clamped to
// the mailbox bank. A finish transaction (tuser = 1) closes the list. Init (2)
// and accept (3) transactions pick the segment owning the mailbox; init takes
// its next entry round robin, accept the next one under the duplicate limit,
// and each returns one result transaction. A load that opens a segment and a
// finish run a serial divide of one bit per cycle, then a segment update.
// Accept walks the segment through the duplicate-count memory, one read and
// one check per visited entry, then reads, clears and writes the mailbox map.
// One transaction is in work at a time; a finished result waits in the output
// register while the next input is taken. The list memories have no reset and
// no clearing pass: entries are valid once loaded.
module can_mailbox_id_scheduler_core
    import cms_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int SEGMENTS  = SEGMENTS_DEF,
    parameter int MAILBOXES = MAILBOXES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // can_id[10:0], frame_length[14:11], cycle_time[30:15], mailbox[35:31]
    input  logic [S_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_mailbox[4:0], out_can_id[15:5], out_length[19:16], out_entry[25:20]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int KW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int TW  = $clog2(SEGMENTS + 1);
    localparam int BW  = $clog2(MAILBOXES + 1);
    localparam int MAW = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
    localparam int SW  = $clog2(ENTRIES + 2);
    localparam int LW  = ((CW + 1 > BW) ? CW + 1 : BW) + 1;
    localparam int XW  = ((BW > MBOX_W) ? BW : MBOX_W) + 1;
    localparam int DCW = $clog2(CW + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_SEG    = 4'd2;
    localparam logic [3:0] S_INIT   = 4'd3;
    localparam logic [3:0] S_STEP   = 4'd4;
    localparam logic [3:0] S_CHK    = 4'd5;
    localparam logic [3:0] S_MAPRD  = 4'd6;
    localparam logic [3:0] S_MAPCLR = 4'd7;
    localparam logic [3:0] S_MAPWR  = 4'd8;
    localparam logic [3:0] S_RES    = 4'd9;

    // Input field split
    logic [ID_W-1:0]   in_id;
    logic [LEN_W-1:0]  in_len;
    logic [CYC_W-1:0]  in_cyc;
    logic [MBOX_W-1:0] in_mbox;
    assign in_id   = s_tdata[10:0];
    assign in_len  = s_tdata[14:11];
    assign in_cyc  = s_tdata[30:15];
    assign in_mbox = s_tdata[35:31];

    // Control and list state
    logic [3:0]         state_reg;
    logic [DUP_W-1:0]   dup_limit_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [CYC_W-1:0]   max_cyc_reg;
    logic [CW-1:0]      count_reg;
    logic [KW-1:0]      open_reg;
    logic [TW-1:0]      total_reg;
    logic               closed_reg;
    logic               finish_reg;

    // Segment table
    logic [AW-1:0] seq_start_reg [SEGMENTS];
    logic [AW-1:0] seq_end_reg   [SEGMENTS];
    logic [AW-1:0] cursor_reg    [SEGMENTS];
    logic [BW-1:0] box_start_reg [SEGMENTS];
    logic [BW-1:0] box_end_reg   [SEGMENTS];

    logic [MAILBOXES-1:0] map_valid_reg;

    // Item in work
    logic [MBOX_W-1:0] mbox_reg;
    logic [KW-1:0]     seg_reg;
    logic [AW-1:0]     n_reg;
    logic [AW-1:0]     e_reg;
    logic [SW-1:0]     steps_reg;

    // Serial divider
    logic [CW-1:0]      div_pos_reg;
    logic [CW-1:0]      div_num_reg;
    logic [CW-1:0]      div_q_reg;
    logic [RATIO_W-1:0] div_rem_reg;
    logic [DCW-1:0]     div_cnt_reg;

    // Output register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    // Memories
    logic                    ent_we;
    logic [AW-1:0]           ent_waddr;
    logic [ID_W+LEN_W-1:0]   ent_rdata;
    logic                    cnt_we;
    logic [AW-1:0]           cnt_waddr;
    logic [DUP_W-1:0]        cnt_wdata;
    logic [AW-1:0]           cnt_raddr;
    logic [DUP_W-1:0]        cnt_rdata;
    logic [AW-1:0]           map_rdata;

    logic in_acc;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Load position after an implied list restart
    logic [CW-1:0] load_pos;
    assign load_pos = closed_reg ? '0 : count_reg;

    // Segment that owns the incoming mailbox; highest match wins
    logic [KW-1:0] find_k;
    always_comb
    begin
        find_k = '0;
        for (int k = 0; k < SEGMENTS; k++)
        begin
            if ((TW'(k) < total_reg) && (XW'(in_mbox) >= XW'(box_start_reg[k]))
                && (XW'(in_mbox) <= XW'(box_end_reg[k])))
            begin
                find_k = KW'(k);
            end
        end
    end

    // Divider step
    logic [RATIO_W-1:0] ratio_eff;
    logic [RATIO_W:0]   div_sh;
    logic               div_ge;
    assign ratio_eff = (ratio_reg == '0) ? RATIO_W'(1) : ratio_reg;
    assign div_sh    = {div_rem_reg, div_num_reg[CW-1]};
    assign div_ge    = div_sh >= {1'b0, ratio_eff};

    // Rounded-up box number and its clamped forms
    logic [LW-1:0] box_b;
    logic [BW-1:0] box_end_val;
    logic [BW-1:0] box_start_val;
    assign box_b = LW'(div_q_reg) + LW'(div_rem_reg != '0);
    assign box_end_val   = (box_b > LW'(MAILBOXES)) ? BW'(MAILBOXES - 1) : BW'(box_b - LW'(1));
    assign box_start_val = (box_b > LW'(MAILBOXES)) ? BW'(MAILBOXES) : BW'(box_b);

    // Walk helpers
    logic [AW-1:0] walk_next;
    logic [AW-1:0] init_next;
    assign walk_next = (n_reg < seq_end_reg[seg_reg]) ? n_reg + AW'(1)
                                                      : seq_start_reg[seg_reg];
    assign init_next = (cursor_reg[seg_reg] < seq_end_reg[seg_reg])
                       ? cursor_reg[seg_reg] + AW'(1) : seq_start_reg[seg_reg];

    logic cnt_ok;
    assign cnt_ok = cnt_rdata <= dup_limit_reg;

    logic [AW-1:0] map_old;
    assign map_old = map_valid_reg[MAW'(mbox_reg)] ? map_rdata : '0;

    // Memory port steering
    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = load_pos[AW-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = load_pos[AW-1:0];
        cnt_wdata = DUP_W'(1);
        cnt_raddr = walk_next;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_tuser == FUNC_LOAD) && (load_pos < CW'(ENTRIES)))
                begin
                    ent_we = 1'b1;
                    cnt_we = 1'b1;
                end
            end
            S_INIT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = cursor_reg[seg_reg];
                cnt_wdata = '0;
            end
            S_CHK:
            begin
                cnt_we    = cnt_ok;
                cnt_waddr = n_reg;
                cnt_wdata = (cnt_rdata == DUP_MAX) ? DUP_MAX : cnt_rdata + DUP_W'(1);
            end
            S_MAPCLR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = map_old;
                cnt_wdata = '0;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    cms_ram #(.WIDTH(ID_W + LEN_W), .DEPTH(ENTRIES), .AW(AW)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata ({in_len, in_id}),
        .raddr (e_reg),
        .rdata (ent_rdata)
    );

    cms_ram #(.WIDTH(DUP_W), .DEPTH(ENTRIES), .AW(AW)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    cms_ram #(.WIDTH(AW), .DEPTH(MAILBOXES), .AW(MAW)) u_map_ram (
        .clk   (clk),
        .we    (state_reg == S_MAPWR),
        .waddr (MAW'(mbox_reg)),
        .wdata (e_reg),
        .raddr (MAW'(mbox_reg)),
        .rdata (map_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dup_limit_reg <= '0;
            ratio_reg     <= RATIO_W'(2);
            max_cyc_reg   <= '0;
            count_reg     <= '0;
            open_reg      <= '0;
            total_reg     <= '0;
            closed_reg    <= 1'b0;
            finish_reg    <= 1'b0;
            map_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            mbox_reg      <= '0;
            seg_reg       <= '0;
            n_reg         <= '0;
            e_reg         <= '0;
            steps_reg     <= '0;
            div_pos_reg   <= '0;
            div_num_reg   <= '0;
            div_q_reg     <= '0;
            div_rem_reg   <= '0;
            div_cnt_reg   <= '0;
            for (int k = 0; k < SEGMENTS; k++)
            begin
                seq_start_reg[k] <= '0;
                seq_end_reg[k]   <= '0;
                cursor_reg[k]    <= '0;
                box_start_reg[k] <= '0;
                box_end_reg[k]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DUP_LIMIT: dup_limit_reg <= cfg_wdata[DUP_W-1:0];
                    CFG_RATIO:     ratio_reg     <= cfg_wdata[RATIO_W-1:0];
                    default:       ratio_reg     <= ratio_reg;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it now
            if (m_tvalid && m_tready && (state_reg != S_RES))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        mbox_reg <= in_mbox;
                        seg_reg  <= find_k;
                        n_reg    <= cursor_reg[find_k];
                        steps_reg <= '0;
                        unique case (s_tuser)
                            FUNC_LOAD:
                            begin
                                // Restart the list after a finish
                                if (closed_reg)
                                begin
                                    open_reg         <= '0;
                                    total_reg        <= '0;
                                    closed_reg       <= 1'b0;
                                    seq_start_reg[0] <= '0;
                                    cursor_reg[0]    <= '0;
                                    box_start_reg[0] <= '0;
                                end
                                if (load_pos < CW'(ENTRIES))
                                begin
                                    count_reg <= load_pos + CW'(1);
                                    if (in_cyc > (closed_reg ? '0 : max_cyc_reg))
                                    begin
                                        max_cyc_reg <= in_cyc;
                                        if ((load_pos != '0) && (open_reg < KW'(SEGMENTS - 1)))
                                        begin
                                            finish_reg  <= 1'b0;
                                            div_pos_reg <= load_pos;
                                            div_num_reg <= load_pos;
                                            div_q_reg   <= '0;
                                            div_rem_reg <= '0;
                                            div_cnt_reg <= DCW'(CW);
                                            state_reg   <= S_DIV;
                                        end
                                    end
                                    else if (closed_reg)
                                    begin
                                        max_cyc_reg <= '0;
                                    end
                                end
                            end
                            FUNC_FINISH:
                            begin
                                closed_reg <= 1'b1;
                                if (count_reg == '0)
                                begin
                                    total_reg <= '0;
                                end
                                else
                                begin
                                    finish_reg  <= 1'b1;
                                    div_pos_reg <= count_reg;
                                    div_num_reg <= count_reg;
                                    div_q_reg   <= '0;
                                    div_rem_reg <= '0;
                                    div_cnt_reg <= DCW'(CW);
                                    state_reg   <= S_DIV;
                                end
                            end
                            default:
                            begin
                                // Drop when no segments or mailbox is out of range
                                if ((total_reg != '0) && (XW'(in_mbox) < XW'(MAILBOXES)))
                                begin
                                    state_reg <= (s_tuser == FUNC_INIT) ? S_INIT : S_STEP;
                                end
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    div_rem_reg <= div_ge ? RATIO_W'(div_sh - {1'b0, ratio_eff})
                                          : div_sh[RATIO_W-1:0];
                    div_q_reg   <= {div_q_reg[CW-2:0], div_ge};
                    div_num_reg <= {div_num_reg[CW-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                    if (div_cnt_reg == DCW'(1))
                    begin
                        state_reg <= S_SEG;
                    end
                end
                S_SEG:
                begin
                    // Close the open segment, then open the next or finish
                    seq_end_reg[open_reg] <= AW'(div_pos_reg - CW'(1));
                    box_end_reg[open_reg] <= box_end_val;
                    if (finish_reg)
                    begin
                        total_reg <= TW'(open_reg) + TW'(1);
                    end
                    else
                    begin
                        open_reg                       <= open_reg + KW'(1);
                        seq_start_reg[open_reg + KW'(1)] <= AW'(div_pos_reg);
                        cursor_reg[open_reg + KW'(1)]    <= AW'(div_pos_reg);
                        box_start_reg[open_reg + KW'(1)] <= box_start_val;
                    end
                    state_reg <= S_IDLE;
                end
                S_INIT:
                begin
                    e_reg               <= cursor_reg[seg_reg];
                    cursor_reg[seg_reg] <= init_next;
                    state_reg           <= S_MAPWR;
                end
                S_STEP:
                begin
                    n_reg     <= walk_next;
                    steps_reg <= steps_reg + SW'(1);
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (cnt_ok)
                    begin
                        cursor_reg[seg_reg] <= n_reg;
                        e_reg               <= n_reg;
                        state_reg           <= S_MAPRD;
                    end
                    else if ((n_reg == cursor_reg[seg_reg]) || (steps_reg > SW'(ENTRIES)))
                    begin
                        e_reg     <= cursor_reg[seg_reg];
                        state_reg <= S_MAPRD;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_MAPRD:
                begin
                    state_reg <= S_MAPCLR;
                end
                S_MAPCLR:
                begin
                    state_reg <= S_MAPWR;
                end
                S_MAPWR:
                begin
                    map_valid_reg[MAW'(mbox_reg)] <= 1'b1;
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    // Hold until the output register frees up
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'd0, ENTRY_W'(e_reg), ent_rdata[ID_W+LEN_W-1:ID_W],
                                          ent_rdata[ID_W-1:0], mbox_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The walk step count never exceeds ENTRIES + 1
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (steps_reg <= SW'(ENTRIES + 1)))
        else $error("round-robin walk overran its bound");

    // Segment total never exceeds the table size
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(SEGMENTS))
        else $error("segment total above table size");

    // A load into a full, open list leaves the count alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == FUNC_LOAD) && !closed_reg && (count_reg == CW'(ENTRIES)))
        |=> $stable(count_reg))
        else $error("load into full list changed the entry count");

    // A result is only produced from the result state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RES))
        else $error("result raised outside the result state");
`endif

endmodule

[bench/can_mailbox_id_scheduler_core_tb.sv]
`timescale 1ns / 1ps
module can_mailbox_id_scheduler_core_tb
    import cms_pkg::*;
();

    localparam int N_ENTRIES   = ENTRIES_DEF;
    localparam int N_SEGMENTS  = SEGMENTS_DEF;
    localparam int N_MAILBOXES = MAILBOXES_DEF;
    localparam int ITEM_GOAL   = 1850;
    // Accept may walk a whole segment; give margin
    localparam int SETTLE_CYCLES = 2 * (N_ENTRIES + 1) + 80;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        logic [MBOX_W-1:0]  mbox;
        logic [ID_W-1:0]    can_id;
        logic [LEN_W-1:0]   len;
        logic [ENTRY_W-1:0] entry;
    } assignment_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;

    can_mailbox_id_scheduler_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow state. Integers everywhere so that mailbox bounds
    // past the bank (ratio 1, long lists) are held unclamped as the block
    // computes them before the clamp.
    // ------------------------------------------------------------------
    int dup_limit_q;
    int ratio_q;
    int list_id     [N_ENTRIES];
    int list_len    [N_ENTRIES];
    int list_dups   [N_ENTRIES];
    int seg_first   [N_SEGMENTS];
    int seg_last    [N_SEGMENTS];
    int seg_next    [N_SEGMENTS];
    int seg_mb_lo   [N_SEGMENTS];
    int seg_mb_hi   [N_SEGMENTS];
    int mbox_owner  [N_MAILBOXES];
    int top_cycle;
    int list_size;
    int cur_seg;
    int seg_count;
    bit list_done;

    assignment_t pending_assignments[$];
    int  items_sent;
    int  fail_count;
    bit  rx_idle_en;
    int  rx_stall;
    longint cycle_count;

    function automatic int mailbox_of_pos(int pos);
        int r;
        r = (ratio_q != 0) ? ratio_q : 1;
        return pos / r + ((pos % r) != 0 ? 1 : 0);
    endfunction

    function automatic void seal_segment(int pos);
        int b;
        b = mailbox_of_pos(pos);
        if (pos == 0)
            return;
        seg_last[cur_seg]  = pos - 1;
        seg_mb_hi[cur_seg] = (b > N_MAILBOXES) ? N_MAILBOXES - 1 : b - 1;
    endfunction

    function automatic void open_seg(int k, int pos);
        seg_first[k] = pos;
        seg_next[k]  = pos;
        seg_mb_lo[k] = mailbox_of_pos(pos);
    endfunction

    function automatic void clear_list();
        list_size = 0;
        top_cycle = 0;
        cur_seg   = 0;
        seg_count = 0;
        list_done = 1'b0;
        open_seg(0, 0);
    endfunction

    function automatic void scheduler_reset();
        dup_limit_q = 0;
        ratio_q     = 2;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            list_id[i] = 0;
            list_len[i] = 0;
            list_dups[i] = 0;
        end
        for (int k = 0; k < N_SEGMENTS; k++)
        begin
            seg_first[k] = 0;
            seg_last[k] = 0;
            seg_next[k] = 0;
            seg_mb_lo[k] = 0;
            seg_mb_hi[k] = 0;
        end
        for (int m = 0; m < N_MAILBOXES; m++)
            mbox_owner[m] = 0;
        clear_list();
    endfunction

    // Apply one accepted transaction; queue the assignment it produces, if any
    function automatic void schedule_item(logic [FUNC_W-1:0] fn, int id, int len,
                                          int cyc, int mb);
        int k;
        int e;
        int n;
        int steps;
        assignment_t a;
        if (fn == FUNC_LOAD)
        begin
            if (list_done)
                clear_list();
            if (list_size >= N_ENTRIES)
                return;
            list_id[list_size]   = id;
            list_len[list_size]  = len;
            list_dups[list_size] = 1;
            if (cyc > top_cycle)
            begin
                top_cycle = cyc;
                if (list_size > 0 && cur_seg < N_SEGMENTS - 1)
                begin
                    seal_segment(list_size);
                    cur_seg++;
                    open_seg(cur_seg, list_size);
                end
            end
            list_size++;
            return;
        end
        if (fn == FUNC_FINISH)
        begin
            if (list_size == 0)
                seg_count = 0;
            else
            begin
                seal_segment(list_size);
                seg_count = cur_seg + 1;
            end
            list_done = 1'b1;
            return;
        end
        if (seg_count == 0 || mb >= N_MAILBOXES)
            return;
        // Highest-numbered owner wins; unowned mailboxes fall to segment 0
        k = 0;
        for (int s = 0; s < seg_count; s++)
            if (mb >= seg_mb_lo[s] && mb <= seg_mb_hi[s])
                k = s;
        if (fn == FUNC_INIT)
        begin
            e = seg_next[k];
            seg_next[k] = (e < seg_last[k]) ? e + 1 : seg_first[k];
            if (e < N_ENTRIES)
                list_dups[e] = 0;
        end
        else
        begin
            n = seg_next[k];
            steps = 0;
            do
            begin
                n = (n < seg_last[k]) ? n + 1 : seg_first[k];
                if (n < N_ENTRIES && list_dups[n] <= dup_limit_q)
                begin
                    seg_next[k] = n;
                    if (list_dups[n] < DUP_MAX)
                        list_dups[n]++;
                end
                steps++;
            end
            while (n != seg_next[k] && steps <= N_ENTRIES);
            e = seg_next[k];
            if (mbox_owner[mb] < N_ENTRIES)
                list_dups[mbox_owner[mb]] = 0;
        end
        if (e >= N_ENTRIES)
            e = 0;
        mbox_owner[mb] = e;
        a.mbox   = mb[MBOX_W-1:0];
        a.can_id = list_id[e][ID_W-1:0];
        a.len    = list_len[e][LEN_W-1:0];
        a.entry  = e[ENTRY_W-1:0];
        pending_assignments.push_back(a);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one transaction, hold it until taken, then maybe idle the bus
    task automatic send_item(logic [FUNC_W-1:0] fn, int id, int len, int cyc, int mb,
                             bit gaps);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {4'b0, mb[MBOX_W-1:0], cyc[CYC_W-1:0], len[LEN_W-1:0], id[ID_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        schedule_item(fn, id, len, cyc, mb);
        items_sent++;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every assignment, then let an unseen walk finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DUP_LIMIT)
            dup_limit_q = value & 'hF;
        else
            ratio_q = value & 'h7F;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        write_reg(CFG_DUP_LIMIT, 0);
        write_reg(CFG_RATIO, 2);
        // nothing scheduled yet: init and accept stay silent
        send_item(FUNC_INIT, 0, 0, 0, 0, 1'b1);
        send_item(FUNC_FINISH, 0, 0, 0, 0, 1'b1);
        send_item(FUNC_ACCEPT, 0, 0, 0, 31, 1'b1);
        // entries ahead of the first rise land in segment 0
        send_item(FUNC_LOAD, 0, 0, 0, 0, 1'b1);
        send_item(FUNC_LOAD, 2047, 8, 0, 0, 1'b1);
        send_item(FUNC_LOAD, 1365, 7, 10, 0, 1'b1);
        send_item(FUNC_LOAD, 682, 1, 10, 0, 1'b1);
        send_item(FUNC_LOAD, 100, 5, 20, 0, 1'b1);
        send_item(FUNC_LOAD, 200, 3, 65535, 0, 1'b1);
        send_item(FUNC_LOAD, 300, 2, 65535, 0, 1'b1);
        send_item(FUNC_FINISH, 0, 0, 0, 0, 1'b1);
        // closing twice reseals the same last segment
        send_item(FUNC_FINISH, 0, 0, 0, 0, 1'b1);
        send_item(FUNC_INIT, 0, 0, 0, 0, 1'b1);
        send_item(FUNC_INIT, 0, 0, 0, 0, 1'b1);
        send_item(FUNC_INIT, 0, 0, 0, 0, 1'b1);
        send_item(FUNC_INIT, 0, 0, 0, 31, 1'b1);
        send_item(FUNC_INIT, 0, 0, 0, 1, 1'b1);
        send_item(FUNC_INIT, 0, 0, 0, 2, 1'b1);
        send_item(FUNC_ACCEPT, 0, 0, 0, 0, 1'b1);
        send_item(FUNC_ACCEPT, 0, 0, 0, 31, 1'b1);
        send_item(FUNC_ACCEPT, 0, 0, 0, 2, 1'b1);
        send_item(FUNC_ACCEPT, 0, 0, 0, 3, 1'b1);
        drain();
    endtask

    // One list: build it, close it, then exercise the mailboxes
    task automatic run_list(int n_load, int rise_pct, int n_ops);
        int cyc;
        int r;
        cyc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0;
        for (int i = 0; i < n_load; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                cyc = $urandom_range(0, 65535);   // out-of-order noise
            else if ($urandom_range(0, 99) < rise_pct)
                cyc = (cyc + $urandom_range(1, 9000) > 65535) ? 65535
                      : cyc + $urandom_range(1, 9000);
            send_item(FUNC_LOAD, $urandom_range(0, 2047), $urandom_range(0, 8), cyc,
                      $urandom_range(0, 31), 1'b1);
            // stray mailbox traffic while the list is open gets no answer
            if (i > 0 && $urandom_range(0, 99) < 3)
                send_item($urandom_range(0, 1) ? FUNC_INIT : FUNC_ACCEPT, 0, 0, 0,
                          $urandom_range(0, 31), 1'b1);
        end
        send_item(FUNC_FINISH, $urandom_range(0, 2047), $urandom_range(0, 8),
                  $urandom_range(0, 65535), $urandom_range(0, 31), 1'b1);
        if ($urandom_range(0, 9) == 0)
            send_item(FUNC_FINISH, 0, 0, 0, 0, 1'b1);
        for (int i = 0; i < n_ops; i++)
            send_item($urandom_range(0, 2) == 0 ? FUNC_INIT : FUNC_ACCEPT,
                      $urandom_range(0, 2047), $urandom_range(0, 8),
                      $urandom_range(0, 65535), $urandom_range(0, 31), 1'b1);
    endtask

    task automatic test_random();
        int phase;
        int dl;
        int rt;
        int n_load;
        int rise;
        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            case (phase % 6)
                0: begin dl = 0;  rt = 1;  end
                1: begin dl = 14; rt = 64; end
                2: begin dl = $urandom_range(0, 14); rt = 0; end
                default:
                begin
                    dl = $urandom_range(0, 14);
                    rt = $urandom_range(1, 64);
                end
            endcase
            rx_idle_en = ($urandom_range(0, 4) != 0);
            drain();
            write_reg(CFG_DUP_LIMIT, dl);
            write_reg(CFG_RATIO, rt);
            case ($urandom_range(0, 3))
                0: rise = 100;
                1: rise = 50;
                2: rise = 15;
                default: rise = 0;
            endcase
            n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 70)
                     : $urandom_range(1, 40);
            run_list(n_load, rise, $urandom_range(10, 60));
            phase++;
        end
        rx_idle_en = 1'b1;
        drain();
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, compare each transaction in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        assignment_t got;
        assignment_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[4:0], m_tdata[15:5], m_tdata[19:16], m_tdata[25:20]};
            if (pending_assignments.size() == 0)
            begin
                $display("%0t: unexpected result mailbox %0d id %0d len %0d entry %0d",
                         $time, got.mbox, got.can_id, got.len, got.entry);
                fail_count++;
            end
            else
            begin
                want = pending_assignments.pop_front();
                if (got.mbox !== want.mbox)
                begin
                    $display("%0t: out_mailbox expected %0d actual %0d",
                             $time, want.mbox, got.mbox);
                    fail_count++;
                end
                if (got.can_id !== want.can_id)
                begin
                    $display("%0t: out_can_id expected %0d actual %0d",
                             $time, want.can_id, got.can_id);
                    fail_count++;
                end
                if (got.len !== want.len)
                begin
                    $display("%0t: out_length expected %0d actual %0d",
                             $time, want.len, got.len);
                    fail_count++;
                end
                if (got.entry !== want.entry)
                begin
                    $display("%0t: out_entry expected %0d actual %0d",
                             $time, want.entry, got.entry);
                    fail_count++;
                end
            end
        end
        // Hold ready low for a random stall, mostly short, now and then long
        if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 99) < 30)
        begin
            rx_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                        : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = 1'b0;
        cfg_wdata   = '0;
        items_sent  = 0;
        fail_count  = 0;
        rx_idle_en  = 1'b1;
        rx_stall    = 0;
        cycle_count = 0;
        scheduler_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/cms_pkg.sv
hw/rtl/cms_ram.sv
hw/rtl/can_mailbox_id_scheduler_core.sv
bench/can_mailbox_id_scheduler_core_tb.sv
